// ===== design/gbr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_pkg: shared types and constants for the glyph row renderer
// Font store geometry, code ranges and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gbr_pkg;

  // Font store size in bytes and its split into two byte banks.
  localparam int FONT_BYTES = 282752;
  localparam int FONT_WORDS = (FONT_BYTES + 1) / 2;
  localparam int WORD_AW    = $clog2(FONT_WORDS);

  // GB2312 code range and glyph layout.
  localparam logic [7:0] CODE_MIN   = 8'hA1;
  localparam logic [7:0] CODE_MAX   = 8'hFE;
  localparam int         ROW_CELLS  = 94;
  localparam int         GLYPH_ROWS = 16;
  localparam int         ROW_W      = $clog2(GLYPH_ROWS);
  localparam int         GLYPH_W    = 14;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             write_en;
    logic             capture;
    logic             read_en;
    logic [ROW_W-1:0] row;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic code_ok;
    logic addr_ok;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/gbr_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_datapath: font store, glyph address generation and row output registers
// The store is split into an even and an odd byte bank so that both bytes of
// a glyph row are read in the same cycle.
// ----------------------------------------------------------------------------
module gbr_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gbr_pkg::ctrl_cmd_t  cmd,
  output gbr_pkg::dp_status_t      status,
  input  wire logic [18:0]         font_address,
  input  wire logic [7:0]          font_byte,
  input  wire logic [7:0]          code_high,
  input  wire logic [7:0]          code_low,
  input  wire logic [9:0]          left,
  input  wire logic [9:0]          top,
  input  wire logic [3:0]          color,
  output logic                     strobe,
  output logic [15:0]              row_mask,
  output logic [9:0]               row_x,
  output logic [10:0]              row_y,
  output logic [3:0]               row_color,
  output logic                     last_row
);
  import gbr_pkg::*;

  logic [7:0]         mem_even [0:FONT_WORDS-1];
  logic [7:0]         mem_odd  [0:FONT_WORDS-1];
  logic [WORD_AW-1:0] write_index;
  logic [WORD_AW-1:0] read_index;
  logic [6:0]         zone;
  logic [6:0]         pos;
  logic [GLYPH_W-1:0] glyph_calc;
  logic [GLYPH_W-1:0] glyph;
  logic [9:0]         top_q;
  logic [7:0]         rd_even;
  logic [7:0]         rd_odd;

  // Range checks on the incoming transaction.
  always_comb begin
    status.addr_ok = (32'(font_address) < 32'(FONT_BYTES));
    status.code_ok = (code_high >= CODE_MIN) && (code_high <= CODE_MAX) &&
                     (code_low >= CODE_MIN) && (code_low <= CODE_MAX);
  end

  // Glyph index: zone * 94 + pos, where zone and pos are the code bytes less 0xA1.
  assign zone       = 7'(code_high - CODE_MIN);
  assign pos        = 7'(code_low - CODE_MIN);
  assign glyph_calc = GLYPH_W'(zone) * GLYPH_W'(ROW_CELLS) + GLYPH_W'(pos);

  // Capture the render parameters when a render is accepted.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      glyph     <= glyph_calc;
      row_x     <= left;
      top_q     <= top;
      row_color <= color;
    end
  end

  // Word addresses: each word holds one glyph row (two bytes).
  assign write_index = WORD_AW'(font_address >> 1);
  assign read_index  = WORD_AW'({glyph, cmd.row});

  // Even byte bank: left half of each row.
  always_ff @(posedge clk) begin
    if (cmd.write_en && !font_address[0]) begin
      mem_even[write_index] <= font_byte;
    end
    if (cmd.read_en) begin
      rd_even <= mem_even[read_index];
    end
  end

  // Odd byte bank: right half of each row.
  always_ff @(posedge clk) begin
    if (cmd.write_en && font_address[0]) begin
      mem_odd[write_index] <= font_byte;
    end
    if (cmd.read_en) begin
      rd_odd <= mem_odd[read_index];
    end
  end

  assign row_mask = {rd_even, rd_odd};

  // Row position and last-row flag, aligned with the registered read data.
  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      row_y    <= {1'b0, top_q} + 11'(cmd.row);
      last_row <= (cmd.row == LAST_ROW);
    end
  end

  // Result strobe follows each read in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.read_en;
    end
  end

endmodule
`default_nettype wire

// ===== design/gbr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbr_ctrl: transaction controller for the glyph row renderer
// Accepts load and render transactions and sequences the sixteen row reads.
// ----------------------------------------------------------------------------
module gbr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 mode,
  input  wire gbr_pkg::dp_status_t  status,
  output gbr_pkg::ctrl_cmd_t        cmd,
  output logic                      busy
);
  import gbr_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic             accept;
  logic             render_go;

  assign busy      = (state == ST_READ);
  assign accept    = start && !busy;
  assign render_go = accept && mode && status.code_ok;

  // Commands to the datapath.
  always_comb begin
    cmd.write_en = accept && !mode && status.addr_ok;
    cmd.capture  = render_go;
    cmd.read_en  = (state == ST_READ);
    cmd.row      = row;
  end

  // Next state and row counter.
  always_comb begin
    state_next = state;
    row_next   = row;
    case (state)
      ST_IDLE: begin
        row_next = '0;
        if (render_go) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        row_next = row + 1'b1;
        if (row == LAST_ROW) begin
          state_next = ST_IDLE;
          row_next   = '0;
        end
      end
      default: begin
        state_next = ST_IDLE;
        row_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A valid render starts the read sequence at the first row.
  a_render_starts: assert property (@(posedge clk) disable iff (rst)
    render_go |=> (busy && row == '0))
    else $error("render did not start the row sequence");

  // The sequence ends after the last row.
  a_render_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && row == LAST_ROW) |=> !busy)
    else $error("controller stayed busy after the last row");

  // While idle the row counter rests at zero.
  a_idle_row: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (row == '0))
    else $error("row counter not cleared while idle");

  // No store write while rows are being read.
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.write_en)
    else $error("store write during a render");
`endif

endmodule
`default_nettype wire

// ===== design/gb2312_glyph_row_renderer.sv =====
`default_nettype none
// Load transactions may follow one another every cycle while busy is low.
// A render transaction holds busy while each glyph row is read in turn from
// the two-bank font store. Row results follow one per cycle, the first after
// the state and read data registers; a new transaction waits until busy falls.
// Results cannot be stalled. Synchronous reset returns the controller to idle;
// the font store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// gb2312_glyph_row_renderer: 16x16 GB2312 character generator
// Loads a font store byte by byte and renders a glyph as sixteen row masks.
// ----------------------------------------------------------------------------
module gb2312_glyph_row_renderer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode,
  input  wire logic [18:0] font_address,
  input  wire logic [7:0]  font_byte,
  input  wire logic [7:0]  code_high,
  input  wire logic [7:0]  code_low,
  input  wire logic [9:0]  left,
  input  wire logic [9:0]  top,
  input  wire logic [3:0]  color,
  output logic             strobe,
  output logic [15:0]      row_mask,
  output logic [9:0]       row_x,
  output logic [10:0]      row_y,
  output logic [3:0]       row_color,
  output logic             last_row
);
  import gbr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Transaction controller.
  gbr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Font store and row datapath.
  gbr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .font_address (font_address),
    .font_byte    (font_byte),
    .code_high    (code_high),
    .code_low     (code_low),
    .left         (left),
    .top          (top),
    .color        (color),
    .strobe       (strobe),
    .row_mask     (row_mask),
    .row_x        (row_x),
    .row_y        (row_y),
    .row_color    (row_color),
    .last_row     (last_row)
  );

endmodule
`default_nettype wire
